// File: design/hbd_pkg.sv
package hbd_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int SHIFT_TOTAL = FRAC_BITS + 30;

    localparam int DX_W     = 11;
    localparam int HEIGHT_W = 16;
    localparam int D2_W     = 22;
    localparam int ROOT_W   = 19;
    localparam int SUM_W    = 40;
    localparam int COUNT_W  = 23;
    localparam int DVD_W    = 48;
    localparam int PROD_W   = 60;

    localparam int SQRT_STEPS  = 19;
    localparam int DIVF_STEPS  = 27;
    localparam int DIVA_STEPS  = 48;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_TOOL_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_VERTS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF_VERTS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLATTEN_TARGET = 3'd5;

    localparam logic [1:0] MODE_RAISE   = 2'd0;
    localparam logic [1:0] MODE_LOWER   = 2'd1;
    localparam logic [1:0] MODE_FLATTEN = 2'd2;
    localparam logic [1:0] MODE_SMOOTH  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SQRT,
        ST_DIVF,
        ST_ALPHA,
        ST_SAMUL,
        ST_DIVA,
        ST_PREP,
        ST_MULLO,
        ST_MULHI,
        ST_FIN
    } hbd_state_t;

    typedef struct packed {
        logic capture;
        logic acc_en;
        logic sqrt_start;
        logic divf_start;
        logic diva_start;
        logic alpha_ld;
        logic sa_ld;
        logic prep_ld;
        logic mul_lo;
        logic mul_hi;
        logic out_load;
    } hbd_cmd_t;

    typedef struct packed {
        logic action;
        logic in_disc;
        logic ring;
        logic smooth_div;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } hbd_stat_t;

endpackage

// File: design/heightmap_brush_dab.sv
// One dab of a radial-falloff heightmap sculpt brush. Each input transfer is
// one height sample with its offset from the brush centre. Accumulate
// transfers (action 0) fold in-disc heights into a running sum and count used
// as the smooth average; restart clears both first. Apply transfers
// (action 1) yield one result transfer each with the brushed height, a
// modified flag and the in-disc flag. An item passes a capture state and an
// evaluate state; accumulate ends there, and a sample outside the disc goes
// on to the finish state for its result. An apply inside the disc also runs
// the 19-step square root; a sample on the falloff ring adds the falloff
// division, and smooth adds the 48-bit average division, both through the
// one shared bit-serial divider. Results leave through an output register,
// so a waiting result stalls the block only when the next one is ready. The
// user must write configuration while idle; the block does not enforce it.
module heightmap_brush_dab (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // dx [10:0], dy [21:11], height [37:22], zero fill [39:38]
    input  logic [hbd_pkg::S_TDATA_W-1:0]  s_tdata,
    // action [0], restart [1]
    input  logic [hbd_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_height [15:0]
    output logic [hbd_pkg::M_TDATA_W-1:0]  m_tdata,
    // modified [0], inside_res [1]
    output logic [hbd_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [hbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hbd_pkg::*;

    hbd_cmd_t  cmd;
    hbd_stat_t stat;

    // sequence the square root, divisions and multiplies
    hbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold config, state and the arithmetic units
    hbd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: design/hbd_ctrl.sv
module hbd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hbd_pkg::hbd_stat_t stat,
    output hbd_pkg::hbd_cmd_t  cmd
);
    import hbd_pkg::*;

    hbd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL: begin
                if (!stat.action)       state_next = ST_IDLE;
                else if (!stat.in_disc) state_next = ST_FIN;
                else                    state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (stat.sqrt_done) state_next = stat.ring ? ST_DIVF : ST_ALPHA;
            end
            ST_DIVF:  if (stat.div_done) state_next = ST_ALPHA;
            ST_ALPHA: state_next = ST_SAMUL;
            ST_SAMUL: state_next = stat.smooth_div ? ST_DIVA : ST_PREP;
            ST_DIVA:  if (stat.div_done) state_next = ST_PREP;
            ST_PREP:  state_next = ST_MULLO;
            ST_MULLO: state_next = ST_MULHI;
            ST_MULHI: state_next = ST_FIN;
            ST_FIN:   if (stat.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = 1'b1;
            end
            ST_EVAL: begin
                cmd.acc_en     = !stat.action;
                cmd.sqrt_start = stat.action && stat.in_disc;
            end
            ST_SQRT:  cmd.divf_start = stat.sqrt_done && stat.ring;
            ST_ALPHA: cmd.alpha_ld = 1'b1;
            ST_SAMUL: begin
                cmd.sa_ld      = 1'b1;
                cmd.diva_start = stat.smooth_div;
            end
            ST_PREP:  cmd.prep_ld = 1'b1;
            ST_MULLO: cmd.mul_lo = 1'b1;
            ST_MULHI: cmd.mul_hi = 1'b1;
            ST_FIN:   cmd.out_load = stat.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// File: design/hbd_datapath.sv
module hbd_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hbd_pkg::hbd_cmd_t                  cmd,
    output hbd_pkg::hbd_stat_t                 stat,
    input  logic                               s_tvalid,
    input  logic [hbd_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [hbd_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                               cfg_wr_en,
    input  logic [hbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hbd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [hbd_pkg::M_TUSER_W-1:0]      m_tuser
);
    import hbd_pkg::*;

    // configuration
    logic [1:0]  mode_reg;
    logic [9:0]  radius_reg;
    logic [9:0]  falloff_reg;
    logic [15:0] strength_reg;
    logic [23:0] step_reg;
    logic [24:0] target_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_RAISE;
            radius_reg   <= 10'd1;
            falloff_reg  <= 10'd0;
            strength_reg <= 16'd16384;
            step_reg     <= 24'd32768;
            target_reg   <= 25'd8388608;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TOOL_MODE:      mode_reg     <= cfg_wdata[1:0];
                CFG_RADIUS_VERTS:   radius_reg   <= cfg_wdata[9:0];
                CFG_FALLOFF_VERTS:  falloff_reg  <= cfg_wdata[9:0];
                CFG_STRENGTH:       strength_reg <= cfg_wdata[15:0];
                CFG_RAISE_STEP:     step_reg     <= cfg_wdata[23:0];
                CFG_FLATTEN_TARGET: target_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // captured item
    logic signed [DX_W-1:0] dx_reg, dy_reg;
    logic [HEIGHT_W-1:0]    h_reg;
    logic                   action_reg, restart_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture && s_tvalid) begin
            dx_reg      <= s_tdata[10:0];
            dy_reg      <= s_tdata[21:11];
            h_reg       <= s_tdata[37:22];
            action_reg  <= s_tuser[0];
            restart_reg <= s_tuser[1];
        end
    end

    // disc geometry
    logic [9:0]             r_eff, w_eff;
    logic signed [D2_W-1:0] dx_w, dy_w, dx_sq, dy_sq;
    logic [D2_W-1:0]        d2;
    logic [19:0]            r_w, r_sq;
    logic                   in_disc;
    logic [ROOT_W-1:0]      inner;

    assign r_eff = (radius_reg == 10'd0) ? 10'd1 : radius_reg;
    assign w_eff = (falloff_reg > r_eff) ? r_eff : falloff_reg;
    assign dx_w  = {{(D2_W-DX_W){dx_reg[DX_W-1]}}, dx_reg};
    assign dy_w  = {{(D2_W-DX_W){dy_reg[DX_W-1]}}, dy_reg};
    assign dx_sq = dx_w * dx_w;
    assign dy_sq = dy_w * dy_w;
    assign d2    = dx_sq + dy_sq;
    assign r_w   = {10'd0, r_eff};
    assign r_sq  = r_w * r_w;
    assign in_disc = d2 <= {2'd0, r_sq};
    assign inner = {1'b0, (r_eff - w_eff), 8'd0};

    // running sum and count
    logic [SUM_W-1:0]   sum_reg, sum_base;
    logic [SUM_W:0]     sum_add;
    logic [COUNT_W-1:0] cnt_reg, cnt_base;

    assign sum_base = restart_reg ? '0 : sum_reg;
    assign cnt_base = restart_reg ? '0 : cnt_reg;
    assign sum_add  = {1'b0, sum_base} + {25'd0, h_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.acc_en) begin
            if (in_disc) begin
                sum_reg <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                cnt_reg <= (&cnt_base) ? cnt_base : cnt_base + 1'b1;
            end else begin
                sum_reg <= sum_base;
                cnt_reg <= cnt_base;
            end
        end
    end

    // square root, two radicand bits per step
    logic [37:0]       sq_val_reg;
    logic [21:0]       sq_rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        sq_cnt_reg;
    logic [22:0]       sq_t, sq_trial;
    logic              sq_ge;

    assign sq_t     = {sq_rem_reg[20:0], sq_val_reg[37:36]};
    assign sq_trial = {2'd0, root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_cnt_reg <= '0;
        end else if (cmd.sqrt_start) begin
            sq_cnt_reg <= 5'(SQRT_STEPS);
        end else if (sq_cnt_reg != 5'd0) begin
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            sq_val_reg <= {d2, 16'd0};
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end else if (sq_cnt_reg != 5'd0) begin
            sq_val_reg <= {sq_val_reg[35:0], 2'b00};
            sq_rem_reg <= sq_ge ? 22'(sq_t - sq_trial) : sq_t[21:0];
            root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
        end
    end

    logic ring;
    assign ring = (w_eff != 10'd0) && (root_reg > inner);

    // restoring divider shared by falloff and average
    logic [23:0]        dv_rem_reg;
    logic [DVD_W-1:0]   dv_dvd_reg;
    logic [COUNT_W-1:0] dv_den_reg;
    logic [5:0]         dv_cnt_reg;
    logic [24:0]        dv_t;
    logic               dv_ge;
    logic [ROOT_W-1:0]  num;

    assign num   = root_reg - inner;
    assign dv_t  = {dv_rem_reg, dv_dvd_reg[DVD_W-1]};
    assign dv_ge = dv_t >= {2'd0, dv_den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_cnt_reg <= '0;
        end else if (cmd.divf_start) begin
            dv_cnt_reg <= 6'(DIVF_STEPS);
        end else if (cmd.diva_start) begin
            dv_cnt_reg <= 6'(DIVA_STEPS);
        end else if (dv_cnt_reg != 6'd0) begin
            dv_cnt_reg <= dv_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.divf_start) begin
            dv_rem_reg <= '0;
            dv_dvd_reg <= {num, 8'd0, 21'd0};
            dv_den_reg <= {13'd0, w_eff};
        end else if (cmd.diva_start) begin
            dv_rem_reg <= '0;
            dv_dvd_reg <= {sum_reg, 8'd0};
            dv_den_reg <= cnt_reg;
        end else if (dv_cnt_reg != 6'd0) begin
            dv_rem_reg <= dv_ge ? 24'(dv_t - {2'd0, dv_den_reg}) : dv_t[23:0];
            dv_dvd_reg <= {dv_dvd_reg[DVD_W-2:0], dv_ge};
        end
    end

    // falloff weight and scaled strength
    logic [26:0] frac;
    logic [16:0] alpha_reg;
    logic [32:0] sa_reg;

    assign frac = dv_dvd_reg[26:0];

    always_ff @(posedge aclk) begin
        if (cmd.alpha_ld) begin
            if (!ring)                   alpha_reg <= 17'd65536;
            else if (frac >= 27'd65536)  alpha_reg <= 17'd0;
            else                         alpha_reg <= 17'(27'd65536 - frac);
        end
        if (cmd.sa_ld) begin
            sa_reg <= {17'd0, strength_reg} * {16'd0, alpha_reg};
        end
    end

    // delta magnitude and direction
    logic signed [27:0] tgt, diff;
    logic [27:0]        mag;
    logic [25:0]        b_reg;
    logic               neg_reg;

    assign tgt  = (mode_reg == MODE_SMOOTH) ? {2'd0, dv_dvd_reg[25:0]}
                                            : {{3{target_reg[24]}}, target_reg};
    assign diff = tgt - {4'd0, h_reg, 8'd0};
    assign mag  = diff[27] ? 28'(-diff) : diff;

    always_ff @(posedge aclk) begin
        if (cmd.prep_ld) begin
            if (mode_reg == MODE_RAISE || mode_reg == MODE_LOWER) begin
                b_reg   <= {2'd0, step_reg};
                neg_reg <= (mode_reg == MODE_LOWER);
            end else begin
                b_reg   <= mag[25:0];
                neg_reg <= diff[27];
            end
        end
    end

    // product in two halves
    logic [12:0]       mul_b;
    logic [45:0]       mul_p;
    logic [PROD_W-1:0] prod_reg;

    assign mul_b = cmd.mul_hi ? b_reg[25:13] : b_reg[12:0];
    assign mul_p = sa_reg * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            prod_reg <= {14'd0, mul_p};
        end else if (cmd.mul_hi) begin
            prod_reg <= prod_reg + {1'b0, mul_p, 13'd0};
        end
    end

    // final height
    logic [PROD_W-1:0] base, dn_diff;
    logic [PROD_W:0]   up_sum;
    logic [22:0]       up_h;
    logic [HEIGHT_W-1:0] up_clamp, dn_clamp, nh;
    logic              bypass;

    assign base    = {6'd0, h_reg, 38'd0};
    assign up_sum  = {1'b0, base} + {1'b0, prod_reg};
    assign up_h    = up_sum[PROD_W:SHIFT_TOTAL];
    assign up_clamp = (up_h > 23'd65535) ? 16'hFFFF : up_h[15:0];
    assign dn_diff = base - prod_reg;
    assign dn_clamp = (prod_reg >= base) ? 16'd0 : dn_diff[53:38];
    assign bypass  = !in_disc || (mode_reg == MODE_SMOOTH && cnt_reg == '0);
    assign nh      = bypass ? h_reg : (neg_reg ? dn_clamp : up_clamp);

    // output register
    logic                m_tvalid_reg;
    logic [HEIGHT_W-1:0] out_h_reg;
    logic                out_mod_reg, out_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_h_reg   <= nh;
            out_mod_reg <= (nh != h_reg);
            out_in_reg  <= in_disc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_h_reg;
    assign m_tuser  = {out_in_reg, out_mod_reg};

    assign stat.action     = action_reg;
    assign stat.in_disc    = in_disc;
    assign stat.ring       = ring;
    assign stat.smooth_div = (mode_reg == MODE_SMOOTH) && (cnt_reg != '0);
    assign stat.sqrt_done  = (sq_cnt_reg == 5'd0);
    assign stat.div_done   = (dv_cnt_reg == 6'd0);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

endmodule

// File: design/hbd_checker.sv
module hbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // drop any pending result on reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a sample outside the disc is never modified
    a_outside_unmodified: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> !m_tuser[0])
        else $error("outside sample flagged modified");

    // one item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while item in progress");

endmodule

bind heightmap_brush_dab hbd_checker u_hbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
